// File: hdl/epns_pkg.sv
// Shared types, constants and helpers for the entropy pair Newton solver.
// No dependencies; used by epns_ctrl, epns_dp and the top level.
package epns_pkg;

    localparam int FRAC_BITS_DEF = 24;
    localparam int LIMIT_W       = 8;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd50;
    localparam logic [63:0] LN2_Q32 = 64'd2977044472;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_HEAD,
        ST_LOGZ,
        ST_LOGW,
        ST_GRAD,
        ST_DIV1,
        ST_DIV2,
        ST_DIV3,
        ST_DIV4,
        ST_STEP,
        ST_DONE
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;     // capture inputs, form s and side
        logic start_z;  // pick and clamp start value
        logic log_go;   // start log2 unit
        logic log_sel;  // 0: z, 1: s - z
        logic lz_cap;   // keep log2 of z
        logic grad;     // form gradient
        logic div_go;   // start divider
        logic [1:0] div_sel; // 0: s/z, 1: q/(s-z), 2: |g|/g2
        logic step;     // apply Newton step
        logic it_inc;   // count one iteration
        logic conv_set; // mark converged
        logic finish;   // latch result word
    } cmd_t;

    typedef struct packed {
        logic small_sum;  // s below two LSB
        logic log_done;
        logic div_done;
        logic tol_hit;
        logic limit_hit;  // iterations reached limit
    } stat_t;

    localparam logic [1:0] DSEL_SZ  = 2'd0;
    localparam logic [1:0] DSEL_G2  = 2'd1;
    localparam logic [1:0] DSEL_STP = 2'd2;

endpackage

// File: hdl/epns_log2.sv
// Fixed-length log2 unit: one squaring step per cycle.
// Depends on epns_pkg.
module epns_log2 #(
    parameter int FRAC_BITS = epns_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [25:0] x,
    output logic        done,
    output logic signed [FRAC_BITS+7:0] result
);
    localparam int CW = $clog2(FRAC_BITS + 1);
    localparam int MW = FRAC_BITS + 2;

    logic [MW-1:0] m_reg;
    logic [FRAC_BITS-1:0] frac_reg;
    logic [5:0] p_reg;
    logic [CW-1:0] cnt_reg;
    logic busy_reg, done_reg;
    logic [5:0] p_c;
    logic [2*MW-1:0] sq;
    logic [MW-1:0] m_sq;

    always_comb
    begin
        p_c = '0;
        for (int i = 0; i < 26; i++)
        begin
            if (x[i])
            begin
                p_c = 6'(i);
            end
        end
    end

    assign sq   = m_reg * m_reg;
    assign m_sq = MW'(sq >> FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CW'(FRAC_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            p_reg    <= p_c;
            frac_reg <= '0;
            if (int'(p_c) > FRAC_BITS)
            begin
                m_reg <= MW'({38'd0, x} >> (int'(p_c) - FRAC_BITS));
            end
            else
            begin
                m_reg <= MW'({38'd0, x} << (FRAC_BITS - int'(p_c)));
            end
        end
        else if (busy_reg)
        begin
            // squared mantissa at or above two yields a one bit
            if (m_sq[FRAC_BITS+1])
            begin
                m_reg    <= m_sq >> 1;
                frac_reg <= {frac_reg[FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                m_reg    <= m_sq;
                frac_reg <= {frac_reg[FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    assign done   = done_reg;
    assign result = ((FRAC_BITS+8)'(signed'({1'b0, p_reg})) - (FRAC_BITS+8)'(FRAC_BITS))
                    * (FRAC_BITS+8)'(64'd1 << FRAC_BITS)
                    + (FRAC_BITS+8)'({1'b0, frac_reg});

endmodule

// File: hdl/epns_div.sv
// Restoring divider: floor(n * 2^FRAC_BITS / d), saturating at 2^50.
// Depends on epns_pkg.
module epns_div #(
    parameter int FRAC_BITS = epns_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [63:0] n,
    input  logic [63:0] d,
    output logic        done,
    output logic [63:0] q
);
    localparam logic [63:0] GCAP = 64'd1 << 50;
    localparam int STEPS = 64 + FRAC_BITS;
    localparam int CW = $clog2(STEPS + 1);

    logic [63:0] d_reg, r_reg, nsh_reg;
    logic [50:0] q_reg;
    logic        sat_reg, busy_reg, done_reg;
    logic [CW-1:0] cnt_reg;
    logic [64:0] r_sh;

    // one quotient bit per cycle over the dividend bits and fraction bits
    assign r_sh = {r_reg, nsh_reg[63]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CW'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            d_reg   <= d;
            r_reg   <= '0;
            nsh_reg <= n;
            q_reg   <= '0;
            sat_reg <= (d == 64'd0);
        end
        else if (busy_reg)
        begin
            nsh_reg <= {nsh_reg[62:0], 1'b0};
            if (r_sh >= {1'b0, d_reg})
            begin
                r_reg <= 64'(r_sh - {1'b0, d_reg});
                if (q_reg[50])
                begin
                    sat_reg <= 1'b1;
                end
                q_reg <= {q_reg[49:0], 1'b1};
            end
            else
            begin
                r_reg <= r_sh[63:0];
                if (q_reg[50])
                begin
                    sat_reg <= 1'b1;
                end
                q_reg <= {q_reg[49:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign q    = (sat_reg || {13'd0, q_reg} > GCAP) ? GCAP : {13'd0, q_reg};

endmodule

// File: hdl/epns_dp.sv
// Datapath: operand registers, gradient, Newton step, log2 and divide units.
// Depends on epns_pkg, epns_log2, epns_div.
module epns_dp #(
    parameter int FRAC_BITS = epns_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  epns_pkg::cmd_t     cmd,
    output epns_pkg::stat_t    stat,
    input  logic [7:0]         limit,
    input  logic [30:0]        curvature,
    input  logic signed [31:0] linear_term,
    input  logic [24:0]        first_value,
    input  logic [24:0]        second_value,
    output logic [25:0]        new_first,
    output logic [25:0]        new_second,
    output logic [7:0]         iterations_used,
    output logic               converged
);
    localparam logic [63:0] LN2_F =
        (epns_pkg::LN2_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    localparam logic [63:0] TOL_F = ((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000;

    logic [30:0] a_reg;
    logic signed [31:0] b_reg;
    logic [24:0] c1_reg, c2_reg, c_reg;
    logic [25:0] s_reg, z_reg, w;
    logic pos_reg, conv_reg;
    logic [7:0] it_reg;
    logic signed [FRAC_BITS+7:0] lz_reg, lres;
    logic signed [63:0] g_reg;
    logic [63:0] q_reg, g2_reg;
    logic log_done, div_done;
    logic [63:0] dn, dd, dq;
    logic [25:0] lx;

    assign w = s_reg - z_reg;

    // side test: a*(c2-c1) + b*2^(F+1)
    logic signed [63:0] side;
    assign side = 64'(signed'({1'b0, curvature}))
                  * (64'(signed'({1'b0, second_value})) - 64'(signed'({1'b0, first_value})))
                  + (64'(linear_term) <<< (FRAC_BITS + 1));

    // clamp helper
    function automatic logic [25:0] clampz(input logic [25:0] v, input logic [25:0] s);
        logic [25:0] r;
        r = v;
        if (r < 26'd1)
        begin
            r = 26'd1;
        end
        if (r > s - 26'd1)
        begin
            r = s - 26'd1;
        end
        return r;
    endfunction

    // floor(v / 10) by reciprocal multiplication, exact for its 26-bit operands
    function automatic logic [25:0] div10(input logic [25:0] v);
        logic [57:0] p;
        p = 58'(v) * 58'(32'hCCCC_CCCD);
        return 26'(p >> 35);
    endfunction

    // gradient terms
    logic signed [FRAC_BITS+7:0] dl;
    logic [FRAC_BITS+7:0] dlm;
    logic [63:0] lnm;
    logic signed [26:0] dz;
    logic [25:0] dzm;
    logic [63:0] am;
    logic signed [63:0] g_c;
    logic [63:0] gm;

    assign dl  = lz_reg - lres;
    assign dlm = dl[FRAC_BITS+7] ? (FRAC_BITS+8)'(-dl) : (FRAC_BITS+8)'(dl);
    assign lnm = ((64'(dlm) >> 16) * LN2_F
                 + (((64'(dlm) & 64'hFFFF) * LN2_F) >> 16)) >> (FRAC_BITS - 16);
    assign dz  = signed'({1'b0, z_reg}) - signed'({2'b0, c_reg});
    assign dzm = dz[26] ? 26'(-dz) : 26'(dz);
    assign am  = (64'(a_reg) * 64'(dzm)) >> FRAC_BITS;
    assign g_c = (dl[FRAC_BITS+7] ? -signed'(lnm) : signed'(lnm))
               + (dz[26] ? -signed'(am) : signed'(am))
               + (pos_reg ? 64'(b_reg) : -64'(b_reg));
    assign gm  = g_reg[63] ? 64'(-g_reg) : 64'(g_reg);

    assign lx = cmd.log_sel ? w : z_reg;

    epns_log2 #(.FRAC_BITS(FRAC_BITS)) u_log (
        .clk(clk), .rst_n(rst_n), .go(cmd.log_go), .x(lx),
        .done(log_done), .result(lres)
    );

    always_comb
    begin
        unique case (cmd.div_sel)
            epns_pkg::DSEL_SZ:
            begin
                dn = 64'(s_reg);
                dd = 64'(z_reg);
            end
            epns_pkg::DSEL_G2:
            begin
                dn = q_reg;
                dd = 64'(w);
            end
            default:
            begin
                dn = gm;
                dd = g2_reg;
            end
        endcase
    end

    epns_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .go(cmd.div_go), .n(dn), .d(dd),
        .done(div_done), .q(dq)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            it_reg   <= '0;
            conv_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                it_reg   <= '0;
                conv_reg <= 1'b0;
            end
            if (cmd.it_inc)
            begin
                it_reg <= it_reg + 1'b1;
            end
            if (cmd.conv_set)
            begin
                conv_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg   <= curvature;
            b_reg   <= linear_term;
            c1_reg  <= first_value;
            c2_reg  <= second_value;
            s_reg   <= 26'(first_value) + 26'(second_value);
            pos_reg <= !side[63];
            c_reg   <= side[63] ? second_value : first_value;
        end
        if (cmd.start_z)
        begin
            if ({c_reg, 1'b0} > s_reg)
            begin
                z_reg <= clampz(div10(26'(c_reg)), s_reg);
            end
            else
            begin
                z_reg <= clampz(26'(c_reg), s_reg);
            end
        end
        if (cmd.lz_cap)
        begin
            lz_reg <= lres;
        end
        if (cmd.grad)
        begin
            g_reg <= g_c;
        end
        if (div_done && cmd.div_sel == epns_pkg::DSEL_SZ)
        begin
            q_reg <= dq;
        end
        if (div_done && cmd.div_sel == epns_pkg::DSEL_G2)
        begin
            g2_reg <= 64'(a_reg) + dq;
        end
        if (cmd.step)
        begin
            if (!g_reg[63] && g_reg != 64'sd0)
            begin
                if (dq >= 64'(z_reg))
                begin
                    z_reg <= clampz(div10(z_reg), s_reg);
                end
                else
                begin
                    z_reg <= clampz(z_reg - 26'(dq), s_reg);
                end
            end
            else
            begin
                // a step reaching s or beyond pins z one LSB below s
                z_reg <= (dq >= 64'(w)) ? s_reg - 26'd1
                                        : clampz(z_reg + 26'(dq), s_reg);
            end
        end
        if (cmd.finish)
        begin
            if (s_reg < 26'd2)
            begin
                new_first  <= 26'(c1_reg);
                new_second <= 26'(c2_reg);
            end
            else
            begin
                new_first  <= pos_reg ? z_reg : w;
                new_second <= pos_reg ? w : z_reg;
            end
        end
    end

    assign iterations_used = it_reg;
    assign converged       = conv_reg;

    assign stat.small_sum = (s_reg < 26'd2);
    assign stat.log_done  = log_done;
    assign stat.div_done  = div_done;
    assign stat.tol_hit   = (gm < TOL_F);
    assign stat.limit_hit = (it_reg >= limit);

endmodule

// File: hdl/epns_ctrl.sv
// Controller state machine for the solver: sequences log, gradient and divides.
// Depends on epns_pkg.
module epns_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic            out_fire,
    input  epns_pkg::stat_t stat,
    output epns_pkg::cmd_t  cmd,
    output logic            busy,
    output logic            out_valid
);
    epns_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= epns_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            epns_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = epns_pkg::ST_START;
                end
            end
            epns_pkg::ST_START:
            begin
                if (stat.small_sum)
                begin
                    cmd.finish = 1'b1;
                    state_next = epns_pkg::ST_DONE;
                end
                else
                begin
                    cmd.start_z = 1'b1;
                    state_next  = epns_pkg::ST_HEAD;
                end
            end
            epns_pkg::ST_HEAD:
            begin
                // loop head: check limit then start log of z
                if (stat.limit_hit)
                begin
                    cmd.finish = 1'b1;
                    state_next = epns_pkg::ST_DONE;
                end
                else
                begin
                    cmd.log_go = 1'b1;
                    state_next = epns_pkg::ST_LOGZ;
                end
            end
            epns_pkg::ST_LOGZ:
            begin
                if (stat.log_done)
                begin
                    // keep log2 of z and start log2 of s - z
                    cmd.lz_cap  = 1'b1;
                    cmd.log_go  = 1'b1;
                    cmd.log_sel = 1'b1;
                    state_next  = epns_pkg::ST_LOGW;
                end
            end
            epns_pkg::ST_LOGW:
            begin
                cmd.log_sel = 1'b1;
                if (stat.log_done)
                begin
                    cmd.grad   = 1'b1;
                    state_next = epns_pkg::ST_GRAD;
                end
            end
            epns_pkg::ST_GRAD:
            begin
                if (stat.tol_hit)
                begin
                    cmd.conv_set = 1'b1;
                    cmd.finish   = 1'b1;
                    state_next   = epns_pkg::ST_DONE;
                end
                else
                begin
                    cmd.div_go  = 1'b1;
                    cmd.div_sel = epns_pkg::DSEL_SZ;
                    state_next  = epns_pkg::ST_DIV1;
                end
            end
            epns_pkg::ST_DIV1:
            begin
                cmd.div_sel = epns_pkg::DSEL_SZ;
                if (stat.div_done)
                begin
                    state_next = epns_pkg::ST_DIV2;
                end
            end
            epns_pkg::ST_DIV2:
            begin
                cmd.div_sel = epns_pkg::DSEL_G2;
                cmd.div_go  = 1'b1;
                state_next  = epns_pkg::ST_DIV3;
            end
            epns_pkg::ST_DIV3:
            begin
                cmd.div_sel = epns_pkg::DSEL_G2;
                if (stat.div_done)
                begin
                    state_next = epns_pkg::ST_DIV4;
                end
            end
            epns_pkg::ST_DIV4:
            begin
                cmd.div_sel = epns_pkg::DSEL_STP;
                cmd.div_go  = 1'b1;
                state_next  = epns_pkg::ST_STEP;
            end
            epns_pkg::ST_STEP:
            begin
                cmd.div_sel = epns_pkg::DSEL_STP;
                if (stat.div_done)
                begin
                    cmd.step   = 1'b1;
                    cmd.it_inc = 1'b1;
                    state_next = epns_pkg::ST_HEAD;
                end
            end
            epns_pkg::ST_DONE:
            begin
                out_valid = 1'b1;
                if (out_fire)
                begin
                    state_next = epns_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = epns_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/entropy_pair_newton_solver_unit.sv
// Entropy pair Newton solver: one result word per input word, one solve at a
// time. A solve lasts longer for each full Newton iteration that it runs, and
// for the log2 pair of a last iteration that converges, and longer while the
// result word waits for m_tready. The time is set by the serial log2 squaring
// unit and the bit-serial divider that each iteration runs twice and three
// times in turn.
// The iteration limit can be written only while the block is idle.
// Depends on epns_pkg, epns_ctrl, epns_dp.
module entropy_pair_newton_solver_unit #(
    parameter int FRAC_BITS = epns_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // curvature[30:0], linear_term[62:31], first_value[87:63], second_value[112:88]
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_first[25:0], new_second[51:26], iterations_used[59:52], converged[60]
    output logic [63:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_data
);
    logic [7:0] limit_reg;
    epns_pkg::cmd_t  cmd;
    epns_pkg::stat_t stat;
    logic busy, out_valid;
    logic [25:0] nf, ns;
    logic [7:0] itu;
    logic conv;

    // accept a new limit only between solves
    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= epns_pkg::LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    assign s_tready = !busy;
    assign m_tvalid = out_valid;

    epns_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(s_tvalid && s_tready),
        .out_fire(m_tvalid && m_tready), .stat(stat), .cmd(cmd),
        .busy(busy), .out_valid(out_valid)
    );

    epns_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .limit(limit_reg),
        .curvature(s_tdata[30:0]), .linear_term(s_tdata[62:31]),
        .first_value(s_tdata[87:63]), .second_value(s_tdata[112:88]),
        .new_first(nf), .new_second(ns), .iterations_used(itu), .converged(conv)
    );

    assign m_tdata = {3'd0, conv, itu, ns, nf};

    // hold the result word while it waits
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata));
    // never take a word while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n) !(s_tready && m_tvalid));
    // one solve at a time
    assert property (@(posedge clk) disable iff (!rst_n) s_tvalid && s_tready |=> !s_tready);

endmodule

// File: dv/entropy_pair_newton_solver_unit_test.sv
// Self-checking testbench for entropy_pair_newton_solver_unit: directed table,
// then random solves over several iteration limits, checked against a local solver.
// Depends on epns_pkg and the entropy_pair_newton_solver_unit RTL.
module entropy_pair_newton_solver_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = epns_pkg::FRAC_BITS_DEF;
    localparam longint unsigned LN2_FX  =
        (epns_pkg::LN2_Q32 + (64'd1 << (31 - FB))) >> (32 - FB);
    localparam longint unsigned TOL_FX  = ((64'd1 << FB) + 64'd500) / 64'd1000;
    localparam longint unsigned SAT_CAP = 64'd1 << 50;

    typedef struct {
        logic [30:0] curv;
        logic [31:0] lin;
        logic [24:0] c1;
        logic [24:0] c2;
    } solve_req_t;

    typedef struct {
        logic [25:0] first;
        logic [25:0] second;
        logic [7:0]  iters;
        logic        conv;
    } solve_res_t;

    typedef struct {
        solve_req_t req;
        bit         typed;
        solve_res_t res;
    } dir_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_data;

    solve_res_t   pending_solutions[$];
    logic [7:0]   limit_reg;
    int           errors;
    bit           no_idle;

    entropy_pair_newton_solver_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("** entropy_pair_newton_solver_unit: FAILED **");
        $finish;
    end

    // floor(n * 2^FB / d), saturating
    function automatic longint unsigned frac_quot(longint unsigned n, longint unsigned d);
        longint unsigned q, r;
        if (d == 0)
            return SAT_CAP;
        q = n / d;
        r = n % d;
        if (q > (SAT_CAP >> FB))
            return SAT_CAP;
        for (int i = 0; i < FB; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= d)
            begin
                r = r - d;
                q = q | 1;
            end
        end
        return (q > SAT_CAP) ? SAT_CAP : q;
    endfunction

    function automatic longint fix_log2(longint unsigned x);
        int p;
        longint unsigned m, fr;
        p = 63;
        fr = 0;
        while (p > 0 && x[p] == 1'b0)
            p--;
        if (p > FB)
            m = x >> (p - FB);
        else
            m = x << (FB - p);
        for (int i = 0; i < FB; i++)
        begin
            m = (m * m) >> FB;
            fr = fr << 1;
            if (m >= (64'd2 << FB))
            begin
                m = m >> 1;
                fr = fr | 1;
            end
        end
        return longint'(p - FB) * (longint'(1) << FB) + longint'(fr);
    endfunction

    function automatic longint unsigned times_ln2(longint unsigned u);
        longint unsigned hi, lo;
        hi = (u >> 16) * LN2_FX;
        lo = (u & 64'hFFFF) * LN2_FX;
        return (hi + (lo >> 16)) >> (FB - 16);
    endfunction

    function automatic solve_res_t solve_pair(solve_req_t rq, logic [7:0] lim);
        solve_res_t rs;
        longint unsigned a, c1, c2, s, c, z, gm, g2, dm, mag;
        longint b, side, dl, dz, g;
        bit pos, conv;
        int it;
        a = 64'(rq.curv);
        b = longint'(signed'(rq.lin));
        c1 = 64'(rq.c1);
        c2 = 64'(rq.c2);
        s = c1 + c2;
        conv = 0;
        it = 0;
        if (s < 2)
        begin
            rs.first = 26'(c1);
            rs.second = 26'(c2);
            rs.iters = 8'd0;
            rs.conv = 1'b0;
            return rs;
        end
        side = longint'(a) * (longint'(c2) - longint'(c1)) + b * (longint'(1) << (FB + 1));
        pos = side >= 0;
        c = pos ? c1 : c2;
        z = c;
        if (2 * z > s)
            z = z / 10;
        if (z < 1)
            z = 1;
        if (z > s - 1)
            z = s - 1;
        for (it = 0; it < lim; it++)
        begin
            dl = fix_log2(z) - fix_log2(s - z);
            dz = longint'(z) - longint'(c);
            mag = times_ln2((dl < 0) ? longint'(-dl) : dl);
            g = (dl < 0) ? -longint'(mag) : longint'(mag);
            mag = (a * longint'((dz < 0) ? -dz : dz)) >> FB;
            g = g + ((dz < 0) ? -longint'(mag) : longint'(mag));
            g = g + (pos ? b : -b);
            gm = (g < 0) ? longint'(-g) : g;
            if (gm < TOL_FX)
            begin
                conv = 1;
                break;
            end
            g2 = a + frac_quot(frac_quot(s, z), s - z);
            dm = frac_quot(gm, g2);
            if (g > 0)
            begin
                if (dm >= z)
                    z = z / 10;
                else
                    z = z - dm;
            end
            else
                z = z + dm;
            if (z < 1)
                z = 1;
            if (z > s - 1)
                z = s - 1;
        end
        rs.first = 26'(pos ? z : s - z);
        rs.second = 26'(pos ? s - z : z);
        rs.iters = 8'(it);
        rs.conv = conv;
        return rs;
    endfunction

    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0d, expected %0d", field, got, want);
        errors++;
    endtask

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 4);
    endfunction

    // s_tvalid is left high after a word; the next call lowers it only if it waits
    task automatic send_word(solve_req_t rq, bit typed, solve_res_t typed_res);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, rq.c2, rq.c1, rq.lin, rq.curv};
        do @(posedge clk); while (!s_tready);
        pending_solutions.push_back(typed ? typed_res : solve_pair(rq, limit_reg));
    endtask

    // drop the input valid so the last word is not taken twice, then wait
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_solutions.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_limit(logic [7:0] val);
        @(negedge clk);
        s_tvalid <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        limit_reg = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic solve_req_t rand_req();
        solve_req_t rq;
        case ($urandom_range(0, 3))
            0: rq.curv = 31'($urandom());
            1: rq.curv = 31'($urandom_range(0, 32'h0400_0000));
            default: rq.curv = 31'($urandom_range(0, 32'h1000_0000));
        endcase
        if ($urandom_range(0, 3) == 0)
            rq.lin = $urandom();
        else
            rq.lin = $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
        if ($urandom_range(0, 9) == 0)
        begin
            rq.c1 = 25'($urandom());
            rq.c2 = 25'($urandom());
        end
        else
        begin
            rq.c1 = 25'($urandom_range(1, 32'h0100_0000));
            rq.c2 = 25'($urandom_range(1, 32'h0100_0000));
        end
        return rq;
    endfunction

    // result side: random back-pressure, check each word against the oldest expectation
    initial
    begin
        solve_res_t want;
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            if (pending_solutions.size() == 0)
            begin
                report_mismatch("unexpected result word", m_tdata, 64'd0);
            end
            else
            begin
                want = pending_solutions.pop_front();
                if (m_tdata[25:0] !== want.first)
                    report_mismatch("new_first", m_tdata[25:0], want.first);
                if (m_tdata[51:26] !== want.second)
                    report_mismatch("new_second", m_tdata[51:26], want.second);
                if (m_tdata[59:52] !== want.iters)
                    report_mismatch("iterations_used", m_tdata[59:52], want.iters);
                if (m_tdata[60] !== want.conv)
                    report_mismatch("converged", m_tdata[60], want.conv);
            end
        end
    end

    initial
    begin
        dir_row_t dir_rows[$];
        solve_res_t none;
        logic [7:0] limits[6];
        int counts[6];
        limits = '{8'd1, 8'd0, 8'd7, 8'd255, 8'd12, 8'd50};
        counts = '{60, 30, 150, 20, 180, 60};
        none = '{26'd0, 26'd0, 8'd0, 1'b0};
        errors = 0;
        no_idle = 0;
        limit_reg = epns_pkg::LIMIT_RESET;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;

        // sums below two LSB come back unchanged
        dir_rows.push_back('{'{31'd5, 32'd7, 25'd0, 25'd0}, 1, '{26'd0, 26'd0, 8'd0, 1'b0}});
        dir_rows.push_back('{'{31'd5, 32'd7, 25'd0, 25'd1}, 1, '{26'd0, 26'd1, 8'd0, 1'b0}});
        dir_rows.push_back('{'{31'h7FFF_FFFF, 32'h8000_0000, 25'd1, 25'd0}, 1,
                             '{26'd1, 26'd0, 8'd0, 1'b0}});
        dir_rows.push_back('{'{31'd0, 32'd0, 25'd1, 25'd1}, 0, none});
        dir_rows.push_back('{'{31'd0, 32'd0, 25'h100_0000, 25'h100_0000}, 0, none});
        dir_rows.push_back('{'{31'h7FFF_FFFF, 32'h7FFF_FFFF, 25'd1, 25'h100_0000}, 0, none});
        dir_rows.push_back('{'{31'h7FFF_FFFF, 32'h8000_0000, 25'h100_0000, 25'd1}, 0, none});
        dir_rows.push_back('{'{31'd0, 32'h8000_0000, 25'd1, 25'd1}, 0, none});
        dir_rows.push_back('{'{31'd0, 32'h7FFF_FFFF, 25'd1, 25'd1}, 0, none});
        dir_rows.push_back('{'{31'h0200_0000, 32'd0, 25'h080_0000, 25'h040_0000}, 0, none});
        dir_rows.push_back('{'{31'h0200_0000, 32'hFF00_0000, 25'h080_0000, 25'h040_0000}, 0,
                             none});
        dir_rows.push_back('{'{31'h0100_0000, 32'h0001_0000, 25'h1FF_FFFF, 25'h1FF_FFFF}, 0,
                             none});
        dir_rows.push_back('{'{31'd1, 32'hFFFF_FFFF, 25'd2, 25'h100_0000}, 0, none});
        dir_rows.push_back('{'{31'h0400_0000, 32'd1, 25'd3, 25'd3}, 0, none});

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_word(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

        // sweep the iteration limit, random solves under each setting
        for (int p = 0; p < 6; p++)
        begin
            drain();
            write_limit(limits[p]);
            no_idle = (p == 2);
            for (int k = 0; k < counts[p]; k++)
                send_word(rand_req(), 0, none);
        end
        drain();

        if (errors == 0)
            $display("** entropy_pair_newton_solver_unit: PASSED **");
        else
            $display("** entropy_pair_newton_solver_unit: FAILED **");
        $finish;
    end

endmodule
